// ===== src/avm_pkg.sv =====
`default_nettype none

package avm_pkg;

    // samples in one averaging group (2..16)
    localparam int SAMPLES_PER_AVERAGE = 8;

    localparam int SAMPLE_W = 10;
    localparam int TENTHS_W = 6;
    localparam int SEG_W    = 7;
    localparam int DIGIT_W  = 4;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int SUM_W    = $clog2(SAMPLES_PER_AVERAGE * SAMPLE_MAX + 1);
    localparam int CNT_W    = $clog2(SAMPLES_PER_AVERAGE);

    // item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // digit select codes
    localparam logic PHASE_TENS  = 1'b0;
    localparam logic PHASE_UNITS = 1'b1;

    // hex glyphs, bit0 = segment a
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'h0:    seg = 7'h3F;
            4'h1:    seg = 7'h06;
            4'h2:    seg = 7'h5B;
            4'h3:    seg = 7'h4F;
            4'h4:    seg = 7'h66;
            4'h5:    seg = 7'h6D;
            4'h6:    seg = 7'h7D;
            4'h7:    seg = 7'h07;
            4'h8:    seg = 7'h7F;
            4'h9:    seg = 7'h6F;
            4'hA:    seg = 7'h77;
            4'hB:    seg = 7'h7C;
            4'hC:    seg = 7'h39;
            4'hD:    seg = 7'h5E;
            4'hE:    seg = 7'h79;
            default: seg = 7'h71;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== src/avm_scale.sv =====
`default_nettype none

// group sum -> average -> tenths of a volt, combinational
// both multiplies are by constants, so they reduce to a few shifted adds
module avm_scale import avm_pkg::*; (
    input  wire logic [SUM_W-1:0]    i_sum,
    output logic      [TENTHS_W-1:0] o_tenths
);

    // sum / N as multiply by ceil(2^19 / N), exact for any group sum
    localparam int AVG_SHIFT = 19;
    localparam int AVG_RECIP = ((1 << AVG_SHIFT) + SAMPLES_PER_AVERAGE - 1)
                               / SAMPLES_PER_AVERAGE;
    localparam int AVG_PROD_W = SUM_W + AVG_SHIFT;

    // (avg*33 + 511) / 1023 as multiply by ceil(2^30 / 1023)
    localparam int SCALE_MUL   = 33;
    localparam int SCALE_ROUND = 511;
    localparam int SCALE_SHIFT = 30;
    localparam int SCALE_RECIP = (1 << SCALE_SHIFT) / 1023 + 1;
    localparam int X_W         = $clog2(SAMPLE_MAX * SCALE_MUL + SCALE_ROUND + 1);
    localparam int RECIP_W     = $clog2(SCALE_RECIP + 1);
    localparam int SCALE_PROD_W = X_W + RECIP_W;

    logic [AVG_PROD_W-1:0]   avg_prod;
    logic [SAMPLE_W-1:0]     avg;
    logic [X_W-1:0]          x_val;
    logic [SCALE_PROD_W-1:0] scale_prod;

    assign avg_prod = AVG_PROD_W'(i_sum) * AVG_PROD_W'(AVG_RECIP);
    assign avg      = avg_prod[AVG_SHIFT +: SAMPLE_W];

    assign x_val = X_W'(avg) * X_W'(SCALE_MUL) + X_W'(SCALE_ROUND);
    assign scale_prod = SCALE_PROD_W'(x_val) * SCALE_PROD_W'(SCALE_RECIP);

    assign o_tenths = scale_prod[SCALE_SHIFT +: TENTHS_W];

endmodule

`default_nettype wire

// ===== src/adc_average_voltmeter_display.sv =====
`default_nettype none

// Two-digit voltmeter core. Sample transactions (operation 0) are summed in
// groups of SAMPLES_PER_AVERAGE; at the end of a group the average is scaled
// to tenths of a volt, (avg*33+511)/1023, and stored unless hold is set with
// the group's last sample. Refresh-tick transactions (operation 1) each give
// one result: the seven-segment code of the tens digit, then of the units
// digit on the next tick, alternating, plus the stored value. Samples give no
// result. One transaction is taken per cycle while o_stall is low: the group's
// last sample is added, averaged and scaled in the same cycle (constant
// multiplies only), and the new value is stored at that edge, so a tick in
// the very next cycle already shows it. Each tick's result is registered.
// The output holds two results (output register plus skid stage), so the input
// keeps flowing while one result waits; it stalls only while the skid stage
// holds a result, i.e. with both full.
module adc_average_voltmeter_display import avm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_operation,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_hold,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_digit_select,
    output logic [SEG_W-1:0]         o_segments,
    output logic [TENTHS_W-1:0]      o_shown_tenths
);

    typedef struct packed {
        logic                digit_select;
        logic [SEG_W-1:0]    segments;
        logic [TENTHS_W-1:0] tenths;
    } t_result;

    // split 0..63 into tens and units, compare ladder
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [TENTHS_W-1:0] v);
        logic [DIGIT_W-1:0] t;
        if (v >= TENTHS_W'(60)) begin
            t = 4'd6;
        end else if (v >= TENTHS_W'(50)) begin
            t = 4'd5;
        end else if (v >= TENTHS_W'(40)) begin
            t = 4'd4;
        end else if (v >= TENTHS_W'(30)) begin
            t = 4'd3;
        end else if (v >= TENTHS_W'(20)) begin
            t = 4'd2;
        end else if (v >= TENTHS_W'(10)) begin
            t = 4'd1;
        end else begin
            t = 4'd0;
        end
        return t;
    endfunction

    // accumulator
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_count;
    logic [TENTHS_W-1:0] r_voltage;
    logic                r_phase;

    // output register and skid stage
    logic    r_o_valid, r_k_valid;
    t_result r_o, r_k;

    logic                accept, is_sample, is_tick, group_end, pop;
    logic [TENTHS_W-1:0] scaled;
    t_result             new_res;

    logic [DIGIT_W-1:0] tens, units;

    assign o_stall   = r_k_valid;
    assign accept    = i_valid & ~o_stall;
    assign is_sample = accept & (i_operation == OP_SAMPLE);
    assign is_tick   = accept & (i_operation == OP_TICK);
    assign group_end = is_sample & (r_count == CNT_W'(SAMPLES_PER_AVERAGE - 1));
    assign n_sum     = r_sum + SUM_W'(i_sample);

    // completed group sum -> tenths, same cycle
    avm_scale u_scale (
        .i_sum    (n_sum),
        .o_tenths (scaled)
    );

    // digit decode for the tick
    assign tens  = tens_of(r_voltage);
    assign units = DIGIT_W'(r_voltage - TENTHS_W'(tens) * TENTHS_W'(10));

    assign new_res.digit_select = r_phase;
    assign new_res.segments     = seg_decode((r_phase == PHASE_TENS) ? tens : units);
    assign new_res.tenths       = r_voltage;

    assign pop = r_o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_count   <= '0;
            r_voltage <= '0;
            r_phase   <= PHASE_TENS;
            r_o_valid <= 1'b0;
            r_k_valid <= 1'b0;
        end else begin
            if (group_end) begin
                r_sum   <= '0;
                r_count <= '0;
                // hold only counts on the group's last sample
                if (!i_hold) begin
                    r_voltage <= scaled;
                end
            end else if (is_sample) begin
                r_sum   <= n_sum;
                r_count <= r_count + CNT_W'(1);
            end

            if (is_tick) begin
                r_phase <= ~r_phase;
            end

            // two-entry result queue; skid full blocks any new tick
            if (pop) begin
                if (r_k_valid) begin
                    r_o       <= r_k;
                    r_k_valid <= 1'b0;
                end else if (is_tick) begin
                    r_o <= new_res;
                end else begin
                    r_o_valid <= 1'b0;
                end
            end else if (is_tick) begin
                if (!r_o_valid) begin
                    r_o       <= new_res;
                    r_o_valid <= 1'b1;
                end else begin
                    r_k       <= new_res;
                    r_k_valid <= 1'b1;
                end
            end
        end
    end

    assign o_valid        = r_o_valid;
    assign o_digit_select = r_o.digit_select;
    assign o_segments     = r_o.segments;
    assign o_shown_tenths = r_o.tenths;

endmodule

`default_nettype wire
